// ----- rtl/core/msk_pkg.sv -----
// Shared types and constants for the Morse keyer: channel words, phase codes,
// character decode record and the fixed code table.
// No dependencies.
package msk_pkg;

   localparam int TC_W = 19;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [7:0] CHAR_END   = 8'd0;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_BANG  = 8'd33;
   localparam logic [7:0] CHAR_FIRST = 8'd44;
   localparam logic [7:0] CHAR_LAST  = 8'd90;
   localparam logic [7:0] BANG_CODE  = 8'hEB;

   localparam logic [15:0] DIT_RESET = 16'd100;

   // Top three bits: element count; below: dah(1)/dit(0) pattern, MSB first.
   // Top two bits 11 mark a six-element code with a six-bit pattern.
   localparam logic [7:0] CODE_TABLE [0:46] = '{
      8'hF3, 8'h00, 8'hD5, 8'hB2, 8'hBF, 8'hAF, 8'hA7, 8'hA3, 8'hA1, 8'hA0,
      8'hB0, 8'hB8, 8'hBC, 8'hBE, 8'h00, 8'h00, 8'h00, 8'hB1, 8'h00, 8'hCC,
      8'h00, 8'h48, 8'h90, 8'h94, 8'h70, 8'h20, 8'h84, 8'h78, 8'h80, 8'h40,
      8'h8E, 8'h74, 8'h88, 8'h58, 8'h50, 8'h7C, 8'h8C, 8'h9A, 8'h68, 8'h60,
      8'h30, 8'h64, 8'h82, 8'h6C, 8'h92, 8'h96, 8'h98
   };

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] next_char;
   } req_type;

   typedef struct packed {
      logic tone_on;
      logic char_taken;
      logic ready_res;
   } rsp_type;

   typedef enum logic [8:0] {
      PH_STOPPED   = 9'b000000001,
      PH_START     = 9'b000000010,
      PH_NEXTCHAR  = 9'b000000100,
      PH_NEXTBIT   = 9'b000001000,
      PH_DIT       = 9'b000010000,
      PH_DAH       = 9'b000100000,
      PH_BITGAP    = 9'b001000000,
      PH_LETTERGAP = 9'b010000000,
      PH_SPACE     = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic       is_space;
      logic       is_end;
      logic [2:0] count;
      logic [7:0] pattern;
   } chr_type;

endpackage

// ----- rtl/core/msk_lookup.sv -----
// Character decoder: classifies one ASCII code and unpacks its Morse entry.
// Depends on msk_pkg (code table, chr_type).
module msk_lookup
   import msk_pkg::*;
(
   input  logic [7:0] chr,
   output chr_type    info
);

   logic [7:0] entry;
   logic [5:0] idx;

   always_comb begin
      idx   = 6'(chr - CHAR_FIRST);
      entry = BANG_CODE;
      info  = '0;
      if (chr == CHAR_SPACE) begin
         info.is_space = 1'b1;
      end else if (chr == CHAR_END || (chr < CHAR_FIRST && chr != CHAR_BANG) ||
                   chr > CHAR_LAST) begin
         info.is_end = 1'b1;
      end else begin
         if (chr != CHAR_BANG) begin
            entry = CODE_TABLE[idx];
         end
         if (entry[7:6] == 2'b11) begin
            info.count   = 3'd6;
            info.pattern = {entry[5:0], 2'b00};
         end else begin
            info.count   = entry[7:5];
            info.pattern = {entry[4:0], 3'b000};
         end
      end
   end

endmodule

// ----- rtl/core/morse_code_sender_unit.sv -----
// A word held in the input register is keyed into the result register when the result register moves on.
// Throughput: one word per cycle; the input register and the result register
// each take a new word whenever the stage after them moves on.
// Reset (synchronous): keyer idle, tone off, counters cleared, dit length 100.
// Top level of the tick-driven Morse keyer; depends on msk_pkg and msk_lookup.
module morse_code_sender_unit
   import msk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic [15:0]     dit_ff;
   req_type         req_ff;
   logic            req_valid_ff;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff;
   phase_type       phase_ff, phase_in;
   logic [TC_W-1:0] tick_count_ff, tick_count_in;
   logic [2:0]      elements_ff, elements_in;
   logic [7:0]      pattern_ff, pattern_in;
   logic            tone_ff, tone_in;

   logic            advance;
   logic            fire;
   logic            taken;
   chr_type         info;
   logic [TC_W-1:0] d1, d2, d3, d6, limit, tc_inc;
   logic            over;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid_ff && advance;
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   msk_lookup u_lookup (
      .chr  (req_ff.next_char),
      .info (info)
   );

   // Timed part limits: dit and bit gap d, letter gap 2d, dah 3d, word space 6d.
   assign d1     = TC_W'(dit_ff);
   assign d2     = d1 << 1;
   assign d3     = d1 + d2;
   assign d6     = d3 << 1;
   assign tc_inc = tick_count_ff + 1'b1;

   always_comb begin
      unique case (phase_ff)
         PH_DAH:       limit = d3;
         PH_LETTERGAP: limit = d2;
         PH_SPACE:     limit = d6;
         default:      limit = d1;
      endcase
   end

   assign over = tc_inc > limit;

   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      elements_in   = elements_ff;
      pattern_in    = pattern_ff;
      tone_in       = tone_ff;
      taken         = 1'b0;
      unique case (req_ff.operation)
         OP_TICK: begin
            unique case (phase_ff)
               PH_DIT, PH_DAH: begin
                  if (tick_count_ff == '0) begin
                     tone_in = 1'b1;
                  end
                  if (over) begin
                     tick_count_in = '0;
                     phase_in      = PH_BITGAP;
                  end else begin
                     tick_count_in = tc_inc;
                  end
               end
               PH_BITGAP, PH_LETTERGAP, PH_SPACE: begin
                  if (tick_count_ff == '0) begin
                     tone_in = 1'b0;
                  end
                  tick_count_in = tc_inc;
                  if (over) begin
                     phase_in = (phase_ff == PH_BITGAP) ? PH_NEXTBIT : PH_NEXTCHAR;
                  end
               end
               PH_NEXTBIT: begin
                  tick_count_in = '0;
                  pattern_in    = {pattern_ff[6:0], 1'b0};
                  if (elements_ff == '0) begin
                     phase_in = PH_LETTERGAP;
                  end else begin
                     phase_in    = pattern_ff[7] ? PH_DAH : PH_DIT;
                     elements_in = elements_ff - 1'b1;
                  end
               end
               PH_NEXTCHAR: begin
                  taken = 1'b1;
                  if (info.is_space) begin
                     tick_count_in = '0;
                     phase_in      = PH_SPACE;
                  end else if (info.is_end) begin
                     phase_in = PH_STOPPED;
                  end else begin
                     pattern_in  = info.pattern;
                     elements_in = info.count;
                     phase_in    = PH_NEXTBIT;
                  end
               end
               PH_START: begin
                  tone_in       = 1'b0;
                  tick_count_in = '0;
                  phase_in      = PH_NEXTCHAR;
               end
               default: begin
                  phase_in = PH_STOPPED;
               end
            endcase
         end
         OP_START: begin
            if (phase_ff == PH_STOPPED) begin
               phase_in = PH_START;
            end
         end
         OP_STOP: begin
            tone_in  = 1'b0;
            phase_in = PH_STOPPED;
         end
         default: begin
         end
      endcase
      rsp_in.tone_on    = tone_in;
      rsp_in.char_taken = taken;
      rsp_in.ready_res  = (phase_in == PH_STOPPED);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dit_ff        <= DIT_RESET;
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_STOPPED;
         tick_count_ff <= '0;
         elements_ff   <= '0;
         pattern_ff    <= '0;
         tone_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            dit_ff <= csr_data;
         end
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (fire) begin
            phase_ff      <= phase_in;
            tick_count_ff <= tick_count_in;
            elements_ff   <= elements_in;
            pattern_ff    <= pattern_in;
            tone_ff       <= tone_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Keyer state may only move when a word is processed.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(phase_ff) && $stable(tick_count_ff) && $stable(tone_ff))
      else $error("keyer state changed without a processed word");

   // A fetch always happens after a silent gap or start.
   a_fetch_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.char_taken |-> !rsp_data.tone_on)
      else $error("character fetched while tone on");

   // Idle keyer never drives the beeper.
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ready_res |-> !rsp_data.tone_on)
      else $error("tone on while idle");

endmodule

// ----- tb/morse_code_sender_unit_checker.sv -----
// Watches the keyer's request, result and register channels, predicts each result word
// from its own model of the keyer, and counts each result word that differs. Depends on msk_pkg.
module morse_code_sender_unit_checker
   import msk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0]     dit_len;
   phase_type       key_phase;
   logic [TC_W-1:0] tick_cnt;
   logic [2:0]      elems_left;
   logic [7:0]      dah_bits;
   logic            tone_q;
   rsp_type         keying_q [$];

   // Count one tick of a timed part; true once the part is over.
   function automatic logic part_done(int unsigned limit);
      tick_cnt = tick_cnt + 1'b1;
      return 32'(tick_cnt) > limit;
   endfunction

   function automatic void fetch_char(logic [7:0] ch);
      logic [7:0] code;
      if (ch == CHAR_SPACE) begin
         tick_cnt  = '0;
         key_phase = PH_SPACE;
      end else if (ch == CHAR_END || (ch < CHAR_FIRST && ch != CHAR_BANG) || ch > CHAR_LAST) begin
         key_phase = PH_STOPPED;
      end else begin
         code = (ch == CHAR_BANG) ? BANG_CODE : CODE_TABLE[ch - CHAR_FIRST];
         if (code[7:6] == 2'b11) begin
            dah_bits   = code << 2;
            elems_left = 3'd6;
         end else begin
            dah_bits   = code << 3;
            elems_left = code[7:5];
         end
         key_phase = PH_NEXTBIT;
      end
   endfunction

   function automatic rsp_type key_step(req_type w);
      int unsigned d;
      logic        taken;
      rsp_type     r;
      d     = 32'(dit_len);
      taken = 1'b0;
      if (w.operation == OP_TICK) begin
         case (key_phase)
            PH_DIT, PH_DAH: begin
               if (tick_cnt == 0) tone_q = 1'b1;
               if (part_done(key_phase == PH_DIT ? d : 3 * d)) begin
                  tick_cnt  = '0;
                  key_phase = PH_BITGAP;
               end
            end
            PH_BITGAP: begin
               if (tick_cnt == 0) tone_q = 1'b0;
               if (part_done(d)) key_phase = PH_NEXTBIT;
            end
            PH_LETTERGAP, PH_SPACE: begin
               if (tick_cnt == 0) tone_q = 1'b0;
               if (part_done(key_phase == PH_LETTERGAP ? 2 * d : 6 * d))
                  key_phase = PH_NEXTCHAR;
            end
            PH_NEXTBIT: begin
               tick_cnt  = '0;
               key_phase = dah_bits[7] ? PH_DAH : PH_DIT;
               dah_bits  = dah_bits << 1;
               if (elems_left == 0) key_phase = PH_LETTERGAP;
               else elems_left = elems_left - 1'b1;
            end
            PH_NEXTCHAR: begin
               taken = 1'b1;
               fetch_char(w.next_char);
            end
            PH_START: begin
               tone_q    = 1'b0;
               tick_cnt  = '0;
               key_phase = PH_NEXTCHAR;
            end
            PH_STOPPED: ;
            default: key_phase = PH_STOPPED;
         endcase
      end else if (w.operation == OP_START) begin
         if (key_phase == PH_STOPPED) key_phase = PH_START;
      end else if (w.operation == OP_STOP) begin
         tone_q    = 1'b0;
         key_phase = PH_STOPPED;
      end
      r.tone_on    = tone_q;
      r.char_taken = taken;
      r.ready_res  = (key_phase == PH_STOPPED);
      return r;
   endfunction

   task automatic report_field(string name, logic want, logic got);
      $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
      fail_count <= fail_count + 1;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         dit_len       = DIT_RESET;
         key_phase     = PH_STOPPED;
         tick_cnt      = '0;
         elems_left    = '0;
         dah_bits      = '0;
         tone_q        = 1'b0;
         keying_q.delete();
         fail_count    <= 0;
         pending_words <= 0;
      end else begin
         if (csr_valid && csr_ready) dit_len = csr_data;
         if (req_valid && req_ready) keying_q.push_back(key_step(req_data));
         if (rsp_valid && rsp_ready) begin
            if (keying_q.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %b",
                        $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = keying_q.pop_front();
               if (want.tone_on !== rsp_data.tone_on)
                  report_field("tone_on", want.tone_on, rsp_data.tone_on);
               else if (want.char_taken !== rsp_data.char_taken)
                  report_field("char_taken", want.char_taken, rsp_data.char_taken);
               else if (want.ready_res !== rsp_data.ready_res)
                  report_field("ready_res", want.ready_res, rsp_data.ready_res);
            end
         end
         pending_words <= keying_q.size();
      end
   end

endmodule

// ----- tb/morse_code_sender_unit_test.sv -----
// Top of the keyer testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on msk_pkg, morse_code_sender_unit and morse_code_sender_unit_checker.
module morse_code_sender_unit_test;
   import msk_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 1000;
   localparam int SQUEEZE_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;
   int          fail_count;
   int          pending_words;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;
   bit          squeeze_now = 1'b0;
   bit          squeezed = 1'b0;

   always #4 clock = ~clock;

   morse_code_sender_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   morse_code_sender_unit_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   task automatic send_word(logic [1:0] op, logic [7:0] ch);
      if (!quiet && !squeeze_now && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{operation: op, next_char: ch};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drain every word in flight, then load a new dit length.
   task automatic write_dit(logic [15:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random();
      int         pick;
      logic [1:0] op;
      logic [7:0] ch;
      pick = $urandom_range(0, 99);
      if (pick < 92) op = OP_TICK;
      else if (pick < 98) op = OP_START;
      else if (pick < 99) op = OP_STOP;
      else op = OP_NOP;
      pick = $urandom_range(0, 99);
      if (pick < 62) ch = CHAR_FIRST + 8'($urandom_range(0, 46));
      else if (pick < 72) ch = CHAR_BANG;
      else if (pick < 84) ch = CHAR_SPACE;
      else if (pick < 90) ch = CHAR_END;
      else ch = 8'($urandom_range(0, 255));
      send_word(op, ch);
   endtask

   // Receiver: random stalls, one long hold-off, none in the quiet tail.
   initial begin
      @(negedge reset);
      forever begin
         if (squeeze_now && !squeezed) begin
            squeezed = 1'b1;
            rsp_ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [15:0] dit_plan [9];
      dit_plan = '{16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd3, 16'd0, 16'd7, 16'd0, 16'd2};
      dit_plan[7] = 16'($urandom_range(0, 4));
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset dit length: ignored operation, stop and tick while idle, start twice
      send_word(OP_NOP, "A");
      send_word(OP_STOP, "A");
      send_word(OP_TICK, "A");
      send_word(OP_START, 8'h00);
      send_word(OP_START, 8'h00);
      send_word(OP_TICK, "E");
      send_word(OP_TICK, "E");
      send_word(OP_TICK, "E");
      send_word(OP_TICK, "E");
      // Shrink the dit mid element, then end of string, invalid, empty entry, space
      write_dit(16'd0);
      send_word(OP_TICK, "E");
      send_word(OP_TICK, "E");
      send_word(OP_TICK, "E");
      send_word(OP_TICK, "E");
      send_word(OP_TICK, CHAR_END);
      send_word(OP_START, "Q");
      send_word(OP_TICK, "Q");
      send_word(OP_TICK, 8'hFF);
      send_word(OP_START, ":");
      send_word(OP_TICK, ":");
      send_word(OP_TICK, ":");
      send_word(OP_TICK, ":");
      send_word(OP_TICK, ":");
      send_word(OP_TICK, CHAR_SPACE);
      send_word(OP_TICK, "a");

      foreach (dit_plan[i]) begin
         write_dit(dit_plan[i]);
         quiet = (i == 8);
         if (dit_plan[i] == 16'hFFFF) begin
            // Park the keyer inside a long dah; the next phase shortens it
            send_word(OP_STOP, "T");
            send_word(OP_START, "T");
            send_word(OP_TICK, "T");
            send_word(OP_TICK, "T");
            repeat (36) send_word(OP_TICK, "T");
         end else begin
            for (int n = 0; n < 100; n++) begin
               if (i == 2) squeeze_now = (n >= 30 && n < 90);
               send_random();
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/msk_pkg.sv
rtl/core/msk_lookup.sv
rtl/core/morse_code_sender_unit.sv
tb/morse_code_sender_unit_checker.sv
tb/morse_code_sender_unit_test.sv
